### src/bbra_pkg.sv
package bbra_pkg;

	localparam int FIELD_BITS = 32;

	typedef struct packed {
		logic [FIELD_BITS-1:0] value_num;
		logic [FIELD_BITS-1:0] value_den;
	} oper_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] approx_num;
		logic [FIELD_BITS-1:0] approx_den;
		logic                  bad_operands;
	} result_t;

	// request to the shared shift/add unit
	typedef struct packed {
		logic start;
		logic div;
	} unit_ctl_t;

	localparam logic UNIT_MUL = 1'b0;
	localparam logic UNIT_DIV = 1'b1;

endpackage

### src/bbra_unit.sv
module bbra_unit #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbra_pkg::unit_ctl_t  ctl,
	input  logic [2*W-1:0]       op_a,
	input  logic [W-1:0]         op_b,
	output logic                 done,
	output logic [3*W-1:0]       prod,
	output logic [W-1:0]         quot,
	output logic [W-1:0]         rem
);
	import bbra_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [2*W:0]   hi_q;
	logic [W-1:0]   lo_q;
	logic [2*W-1:0] a_q;
	logic           div_q;
	logic           run_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;

	logic [2*W:0]   x;
	logic [2*W:0]   y;
	logic [2*W+1:0] sum;
	logic           ge;
	logic [3*W:0]   whole;

	// one adder: add the multiplicand, or subtract the divisor
	always_comb begin
		x = div_q ? {hi_q[2*W-1:0], lo_q[W-1]} : hi_q;
		if (div_q == UNIT_DIV) begin
			y = ~{1'b0, a_q};
		end else begin
			y = lo_q[0] ? {1'b0, a_q} : '0;
		end
		sum = {1'b0, x} + {1'b0, y} + (2*W+2)'(div_q);
		ge = sum[2*W+1];
		whole = {hi_q, lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= ctl.div;
			hi_q <= '0;
			if (ctl.div == UNIT_DIV) begin
				a_q <= {{W{1'b0}}, op_b};
				lo_q <= op_a[W-1:0];
			end else begin
				a_q <= op_a;
				lo_q <= op_b;
			end
		end else if (run_q) begin
			if (div_q == UNIT_DIV) begin
				if (ge) begin
					hi_q <= sum[2*W:0];
					lo_q <= {lo_q[W-2:0], 1'b1};
				end else begin
					hi_q <= x;
					lo_q <= {lo_q[W-2:0], 1'b0};
				end
			end else begin
				hi_q <= {1'b0, sum[2*W:1]};
				lo_q <= {sum[0], lo_q[W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign prod = whole[3*W-1:0];
	assign quot = lo_q;
	assign rem  = hi_q[W-1:0];

endmodule

### src/bounded_best_rational_approx_core.sv
// Bounded best rational approximation.
// Program limit_den (address 0) and limit_num (address 4) over the APB port
// while the core is idle; 0 means unlimited. Pulse start with a fraction on
// operand while busy is low; the transfer happens at that edge. One result
// comes back on result, valid for exactly one cycle while done is high.
// Zero denominators and both-limits-unlimited answer 0/0 with bad_operands
// set in the cycle after start.
// One shift/add unit does every multiply and divide. The integer part
// takes one divide and each further continued-fraction term one divide and
// two multiplies; the final bounding step adds up to two divides and eight
// multiplies.
// Throughput: one item at a time; busy stays high until the result.
// The receiver cannot stall: results are shown once and not held.
// Reset clears both limits and returns the core to idle.
module bounded_best_rational_approx_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bbra_pkg::oper_t   operand,
	output logic              done,
	output bbra_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bbra_pkg::*;

	localparam int W = VALUE_BITS;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DIV0  = 5'd1;
	localparam logic [4:0] S_CHECK = 5'd2;
	localparam logic [4:0] S_DIV   = 5'd3;
	localparam logic [4:0] S_MN    = 5'd4;
	localparam logic [4:0] S_MD    = 5'd5;
	localparam logic [4:0] S_FIN   = 5'd6;
	localparam logic [4:0] S_LD    = 5'd7;
	localparam logic [4:0] S_LN    = 5'd8;
	localparam logic [4:0] S_LIM   = 5'd9;
	localparam logic [4:0] S_SN    = 5'd10;
	localparam logic [4:0] S_SD    = 5'd11;
	localparam logic [4:0] S_F1    = 5'd12;
	localparam logic [4:0] S_F2    = 5'd13;
	localparam logic [4:0] S_F3    = 5'd14;
	localparam logic [4:0] S_F4    = 5'd15;
	localparam logic [4:0] S_F5    = 5'd16;
	localparam logic [4:0] S_F6    = 5'd17;

	localparam logic [W-1:0] MAXV = {W{1'b1}};

	logic [31:0] limit_den_q, limit_num_q;
	logic [4:0]  state_q;
	logic        iss_q;
	logic        done_q;
	logic        bad_q;

	logic [W-1:0] vn_q, vd_q, dm_q, nm_q;
	logic [W-1:0] dv_q, rr_q, a_q;
	logic [W-1:0] cur_n_q, cur_d_q, prev_n_q, prev_d_q;
	logic [W-1:0] u_q, t_q;
	logic         ov_q;
	logic [W-1:0] ld_q, ln_q, l_q, sn_q, sd_q;
	logic [2*W-1:0] t1_q, t2_q;
	logic [3*W-1:0] es_q;
	logic [W-1:0] res_n_q, res_d_q;

	logic [W-1:0] lim_d, lim_n, dm_n, nm_n, vn_in, vd_in;
	logic         accept, in_bad;

	unit_ctl_t      u_ctl;
	logic [2*W-1:0] u_a;
	logic [W-1:0]   u_b;
	logic           u_need;
	logic           u_done;
	logic [3*W-1:0] u_prod;
	logic [W-1:0]   u_quot, u_rem;

	logic [W:0]     madd;
	logic           mov;
	logic [2*W-1:0] adiff;
	logic           ld_ok, ln_ok;
	logic [W-1:0]   lmin, half;
	logic [W:0]     ceil_half;

	bbra_unit #(.W(W)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (u_ctl),
		.op_a   (u_a),
		.op_b   (u_b),
		.done   (u_done),
		.prod   (u_prod),
		.quot   (u_quot),
		.rem    (u_rem)
	);

	always_comb begin
		lim_d = W'(limit_den_q);
		lim_n = W'(limit_num_q);
		dm_n = (lim_d == '0) ? MAXV : lim_d;
		nm_n = (lim_n == '0) ? MAXV : lim_n;
		vn_in = W'(operand.value_num);
		vd_in = W'(operand.value_den);
		accept = start && !busy;
		in_bad = (vd_in == '0) || ((dm_n == MAXV) && (nm_n == MAXV));

		ld_ok = (cur_d_q != '0) && (dm_q >= prev_d_q);
		ln_ok = (cur_n_q != '0) && (nm_q >= prev_n_q);
		lmin = (ln_q < ld_q) ? ln_q : ld_q;
		if (lmin > a_q) lmin = a_q;
		half = a_q >> 1;
		ceil_half = {1'b0, half} + (W+1)'(a_q[0]);

		// low word of the product plus the previous convergent term
		madd = {1'b0, u_prod[W-1:0]}
			+ {1'b0, (state_q == S_MN) ? prev_n_q :
			         (state_q == S_MD) ? prev_d_q :
			         (state_q == S_SN) ? prev_n_q : prev_d_q};
		mov = (u_prod[2*W-1:W] != '0) || madd[W];
		adiff = (t1_q >= u_prod[2*W-1:0]) ? t1_q - u_prod[2*W-1:0]
		                                  : u_prod[2*W-1:0] - t1_q;
		if (state_q == S_F4) begin
			adiff = (t2_q >= u_prod[2*W-1:0]) ? t2_q - u_prod[2*W-1:0]
			                                  : u_prod[2*W-1:0] - t2_q;
		end

		u_need = 1'b1;
		u_ctl.div = UNIT_MUL;
		u_a = '0;
		u_b = '0;
		case (state_q)
			S_DIV0: begin u_ctl.div = UNIT_DIV; u_a = {{W{1'b0}}, vn_q}; u_b = vd_q; end
			S_DIV:  begin u_ctl.div = UNIT_DIV; u_a = {{W{1'b0}}, dv_q}; u_b = rr_q; end
			S_MN:   begin u_a = {{W{1'b0}}, a_q}; u_b = cur_n_q; end
			S_MD:   begin u_a = {{W{1'b0}}, a_q}; u_b = cur_d_q; end
			S_LD: begin
				u_ctl.div = UNIT_DIV;
				u_a = {{W{1'b0}}, dm_q - prev_d_q};
				u_b = cur_d_q;
				u_need = ld_ok;
			end
			S_LN: begin
				u_ctl.div = UNIT_DIV;
				u_a = {{W{1'b0}}, nm_q - prev_n_q};
				u_b = cur_n_q;
				u_need = ln_ok;
			end
			S_SN:   begin u_a = {{W{1'b0}}, l_q}; u_b = cur_n_q; end
			S_SD:   begin u_a = {{W{1'b0}}, l_q}; u_b = cur_d_q; end
			S_F1:   begin u_a = {{W{1'b0}}, vn_q}; u_b = sd_q; end
			S_F2:   begin u_a = {{W{1'b0}}, sn_q}; u_b = vd_q; end
			S_F3:   begin u_a = {{W{1'b0}}, vn_q}; u_b = cur_d_q; end
			S_F4:   begin u_a = {{W{1'b0}}, cur_n_q}; u_b = vd_q; end
			S_F5:   begin u_a = t1_q; u_b = cur_d_q; end
			S_F6:   begin u_a = t2_q; u_b = sd_q; end
			default: u_need = 1'b0;
		endcase
		u_ctl.start = u_need && !iss_q;
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_den_q <= '0;
			limit_num_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				limit_num_q <= pwdata;
			end else begin
				limit_den_q <= pwdata;
			end
		end
	end

	assign prdata = paddr[2] ? limit_num_q : limit_den_q;
	assign pready = 1'b1;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (u_ctl.start) begin
				iss_q <= 1'b1;
			end else if (u_done) begin
				iss_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_bad) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DIV0;
						end
					end
				end
				S_DIV0: if (u_done) state_q <= S_CHECK;
				S_CHECK: begin
					if (ov_q || t_q > dm_q || u_q > nm_q || rr_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (u_done) state_q <= S_MN;
				S_MN:  if (u_done) state_q <= S_MD;
				S_MD:  if (u_done) state_q <= S_CHECK;
				S_FIN: begin
					if (a_q == '0) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= S_LD;
					end
				end
				S_LD: if (u_done || !ld_ok) state_q <= S_LN;
				S_LN: if (u_done || !ln_ok) state_q <= S_LIM;
				S_LIM: begin
					if ({1'b0, lmin} < ceil_half) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= S_SN;
					end
				end
				S_SN: if (u_done) state_q <= S_SD;
				S_SD: begin
					if (u_done) begin
						if (l_q == half) begin
							state_q <= S_F1;
						end else begin
							state_q <= S_IDLE;
							done_q <= 1'b1;
						end
					end
				end
				S_F1: if (u_done) state_q <= S_F2;
				S_F2: if (u_done) state_q <= S_F3;
				S_F3: if (u_done) state_q <= S_F4;
				S_F4: if (u_done) state_q <= S_F5;
				S_F5: if (u_done) state_q <= S_F6;
				S_F6: begin
					if (u_done) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					vn_q <= vn_in;
					vd_q <= vd_in;
					dm_q <= dm_n;
					nm_q <= nm_n;
					cur_n_q <= W'(1);
					cur_d_q <= '0;
					prev_n_q <= '0;
					prev_d_q <= W'(1);
					ov_q <= 1'b0;
					res_n_q <= '0;
					res_d_q <= '0;
					bad_q <= in_bad;
				end
			end
			S_DIV0: begin
				if (u_done) begin
					a_q <= u_quot;
					rr_q <= u_rem;
					dv_q <= vd_q;
					u_q <= u_quot;
					t_q <= W'(1);
				end
			end
			S_CHECK: begin
				if (!(ov_q || t_q > dm_q || u_q > nm_q)) begin
					// take the candidate as the latest convergent
					prev_n_q <= cur_n_q;
					prev_d_q <= cur_d_q;
					cur_n_q <= u_q;
					cur_d_q <= t_q;
					if (rr_q == '0) a_q <= '0;
				end
			end
			S_DIV: begin
				if (u_done) begin
					a_q <= u_quot;
					dv_q <= rr_q;
					rr_q <= u_rem;
				end
			end
			S_MN: begin
				if (u_done) begin
					u_q <= madd[W-1:0];
					ov_q <= mov;
				end
			end
			S_MD: begin
				if (u_done) begin
					t_q <= madd[W-1:0];
					ov_q <= ov_q || mov;
				end
			end
			S_FIN: begin
				res_n_q <= cur_n_q;
				res_d_q <= cur_d_q;
			end
			S_LD: begin
				if (!ld_ok) ld_q <= MAXV;
				else if (u_done) ld_q <= u_quot;
			end
			S_LN: begin
				if (!ln_ok) ln_q <= MAXV;
				else if (u_done) ln_q <= u_quot;
			end
			S_LIM: l_q <= lmin;
			S_SN: if (u_done) sn_q <= madd[W-1:0];
			S_SD: begin
				if (u_done) begin
					sd_q <= madd[W-1:0];
					if (l_q != half) begin
						res_n_q <= sn_q;
						res_d_q <= madd[W-1:0];
					end
				end
			end
			S_F1: if (u_done) t1_q <= u_prod[2*W-1:0];
			S_F2: if (u_done) t1_q <= adiff;
			S_F3: if (u_done) t2_q <= u_prod[2*W-1:0];
			S_F4: if (u_done) t2_q <= adiff;
			S_F5: if (u_done) es_q <= u_prod;
			S_F6: begin
				// keep the convergent when the semiconvergent is farther
				if (u_done && !(es_q > u_prod)) begin
					res_n_q <= sn_q;
					res_d_q <= sd_q;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result.approx_num = 32'(res_n_q);
	assign result.approx_den = 32'(res_d_q);
	assign result.bad_operands = bad_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.bad_operands |-> result.approx_num == 32'd0 &&
			result.approx_den == 32'd0)
		else $error("error result carries a nonzero fraction");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operand.value_den == 32'd0 |=> done && result.bad_operands)
		else $error("zero denominator not flagged at once");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !u_ctl.start)
		else $error("arithmetic unit started while idle");

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbra_pkg::*;

	localparam logic [2:0] ADDR_LIMIT_DEN = 3'd0;
	localparam logic [2:0] ADDR_LIMIT_NUM = 3'd4;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF;
	localparam int STALL_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	oper_t operand = '0;
	logic done;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bounded_best_rational_approx_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operand(operand),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	oper_t fracs_to_send[$];
	result_t approx_expected[$];
	logic [31:0] cur_limit_den = '0;
	logic [31:0] cur_limit_num = '0;
	bit no_gaps = 1'b0;
	int mismatches = 0;
	int fracs_sent = 0;
	int approx_seen = 0;
	int bad_seen = 0;
	int quiet_cycles = 0;

	// r = a*x + y, flag when the exact value leaves 32 bits
	function automatic bit mul_add_over(input logic [63:0] a, x, y, output logic [63:0] r);
		logic [127:0] p;
		p = 128'(a) * 128'(x) + 128'(y);
		r = p[63:0];
		return p > 128'(ALL_ONES);
	endfunction

	function automatic logic [127:0] abs_diff(input logic [127:0] a, b);
		return (a > b) ? a - b : b - a;
	endfunction

	// semiconvergent sn/sd strictly farther from vn/vd than cn/cd
	function automatic bit is_farther(input logic [63:0] vn, vd, sn, sd, cn, cd);
		logic [127:0] es, ec;
		es = abs_diff(128'(vn) * 128'(sd), 128'(sn) * 128'(vd)) * 128'(cd);
		ec = abs_diff(128'(vn) * 128'(cd), 128'(cn) * 128'(vd)) * 128'(sd);
		return es > ec;
	endfunction

	function automatic result_t best_approx(input oper_t f);
		result_t r;
		logic [63:0] vn, vd, dm, nm, x, y, n1, d1, n2, d2, a, u, t;
		logic [63:0] cn, cd, pn, pd, ld, ln, l, sn, sd;
		bit second_latest, ok, over, stop;
		vn = 64'(f.value_num);
		vd = 64'(f.value_den);
		dm = (cur_limit_den == 0) ? ALL_ONES : 64'(cur_limit_den);
		nm = (cur_limit_num == 0) ? ALL_ONES : 64'(cur_limit_num);
		r = '0;
		if (vd == 0 || (dm == ALL_ONES && nm == ALL_ONES)) begin
			r.bad_operands = 1'b1;
			return r;
		end
		x = vn; y = vd;
		n1 = 1; d1 = 0; n2 = 0; d2 = 1;
		a = x / y; u = a; t = 1;
		second_latest = 1'b0;
		ok = (u <= nm) && (t <= dm);
		stop = 1'b0;
		while (ok && !stop) begin
			d2 = t; n2 = u; second_latest = 1'b1;
			x = x % y;
			if (x == 0) begin
				a = 0;
				stop = 1'b1;
			end else begin
				a = y / x;
				over = mul_add_over(a, n2, n1, u);
				over = mul_add_over(a, d2, d1, t) || over;
				if (over || t > dm || u > nm) begin
					stop = 1'b1;
				end else begin
					d1 = t; n1 = u; second_latest = 1'b0;
					y = y % x;
					if (y == 0) begin
						a = 0;
						stop = 1'b1;
					end else begin
						a = x / y;
						over = mul_add_over(a, n1, n2, u);
						over = mul_add_over(a, d1, d2, t) || over;
						ok = !over && t <= dm && u <= nm;
					end
				end
			end
		end
		if (second_latest) begin
			cn = n2; cd = d2; pn = n1; pd = d1;
		end else begin
			cn = n1; cd = d1; pn = n2; pd = d2;
		end
		r.approx_num = cn[31:0];
		r.approx_den = cd[31:0];
		if (a == 0)
			return r;
		ld = (cd != 0 && dm >= pd) ? (dm - pd) / cd : ALL_ONES;
		ln = (cn != 0 && nm >= pn) ? (nm - pn) / cn : ALL_ONES;
		l = (ln < ld) ? ln : ld;
		if (l > a)
			l = a;
		if (l < a / 2 + (a & 1))
			return r;
		sn = l * cn + pn;
		sd = l * cd + pd;
		if (l == a / 2 && is_farther(vn, vd, sn, sd, cn, cd))
			return r;
		r.approx_num = sn[31:0];
		r.approx_den = sd[31:0];
		return r;
	endfunction

	// driver: feed queued fractions, with random gaps
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
		end else begin
			if (start && !busy) begin
				approx_expected.push_back(best_approx(operand));
				void'(fracs_to_send.pop_front());
				fracs_sent++;
			end
			if (gap > 0)
				gap--;
			else if (!no_gaps && $urandom_range(0, 11) == 0)
				gap = $urandom_range(1, 10);
			if (gap == 0 && fracs_to_send.size() > 0) begin
				start <= 1'b1;
				operand <= fracs_to_send[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			approx_seen++;
			if (approx_expected.size() == 0) begin
				$error("result with no expectation: %0d/%0d bad=%0b",
					result.approx_num, result.approx_den, result.bad_operands);
				mismatches++;
			end else begin
				result_t want;
				want = approx_expected.pop_front();
				if (result.bad_operands) bad_seen++;
				if (result.approx_num !== want.approx_num) begin
					$error("approx_num expected %0d got %0d", want.approx_num, result.approx_num);
					mismatches++;
				end
				if (result.approx_den !== want.approx_den) begin
					$error("approx_den expected %0d got %0d", want.approx_den, result.approx_den);
					mismatches++;
				end
				if (result.bad_operands !== want.bad_operands) begin
					$error("bad_operands expected %0b got %0b",
						want.bad_operands, result.bad_operands);
					mismatches++;
				end
			end
		end
	end

	// watchdog: count cycles with no transfer in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("bounded_best_rational_approx_core test failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_LIMIT_DEN)
			cur_limit_den = data;
		else
			cur_limit_num = data;
	endtask

	task automatic set_limits(input logic [31:0] den_lim, num_lim);
		apb_write(ADDR_LIMIT_DEN, den_lim);
		apb_write(ADDR_LIMIT_NUM, num_lim);
	endtask

	// hold until every queued fraction is answered
	task automatic drain();
		wait (fracs_to_send.size() == 0 && approx_expected.size() == 0 && !start);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_frac(input logic [31:0] n, d);
		oper_t f;
		f.value_num = n;
		f.value_den = d;
		fracs_to_send.push_back(f);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 20);
			1: return $urandom_range(0, 5000);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_random(input int count);
		logic [31:0] n, d;
		for (int i = 0; i < count; i++) begin
			d = rand_word();
			n = rand_word();
			if ($urandom_range(0, 24) == 0)
				d = 0;
			else if (d == 0)
				d = 1;
			// near-integer ratios give long final terms and tie cases
			if ($urandom_range(0, 4) == 0)
				n = d * $urandom_range(1, 7) + $urandom_range(0, 3);
			push_frac(n, d);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset limits: both unlimited, every item flagged
		push_frac(32'd3, 32'd7);
		push_frac(32'd5, 32'd0);
		drain();

		set_limits(32'd1000, 32'd0);
		push_frac(32'd355, 32'd113);
		push_frac(32'd0, 32'd5);
		push_frac(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_frac(32'hFFFF_FFFF, 32'd1);
		push_frac(32'd1, 32'hFFFF_FFFF);
		push_frac(32'd0, 32'd0);
		push_frac(32'd3_141_592_653, 32'd1_000_000_000);
		push_frac(32'd1, 32'd2000);
		push_frac(32'd999, 32'd1000);
		drain();

		set_limits(32'd4, 32'd0);
		push_frac(32'd1, 32'd8);
		push_frac(32'd3, 32'd8);
		push_frac(32'd5, 32'd7);
		push_frac(32'd2, 32'd9);
		drain();

		// numerator limit only: integer parts above, at and below it
		set_limits(32'd0, 32'd5);
		push_frac(32'd100, 32'd3);
		push_frac(32'd11, 32'd2);
		push_frac(32'd7, 32'd3);
		push_frac(32'd0, 32'd9);
		drain();

		set_limits(32'd1, 32'd1);
		push_frac(32'd1, 32'd3);
		push_frac(32'd5, 32'd2);
		drain();

		set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_frac(32'd7, 32'd3);
		drain();

		set_limits(32'hFFFF_FFFF, 32'd7);
		push_random(15);
		drain();

		set_limits(32'hFFFF_FFFE, 32'hFFFF_FFFE);
		push_random(20);
		drain();

		for (int p = 0; p < 5; p++) begin
			set_limits($urandom_range(0, 3) == 0 ? 32'd0 : rand_word(),
				$urandom_range(0, 3) == 0 ? 32'd0 : rand_word());
			push_random(15);
			drain();
		end

		no_gaps = 1'b1;
		set_limits(32'd65535, 32'd65535);
		push_random(15);
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d fractions over 14 limit settings, including both extremes;",
			fracs_sent);
		$display("%0d results checked, %0d flagged as bad operands.", approx_seen, bad_seen);
		if (mismatches == 0 && approx_expected.size() == 0)
			$display("bounded_best_rational_approx_core test passed");
		else
			$display("bounded_best_rational_approx_core test failed");
		$finish;
	end

endmodule

### sim.f
src/bbra_pkg.sv
src/bbra_unit.sv
src/bounded_best_rational_approx_core.sv
sim/tb.sv
